FILE: rtl/slfc_pkg.sv
// Shared constants and types for the start/length frame commit block.
`timescale 1ns / 1ps

package slfc_pkg;

  // Field widths fixed by the storage interface.
  localparam int DATA_W = 8;
  localparam int ADDR_W = 5;

  // Frame framing bytes.
  localparam logic [DATA_W-1:0] START_BYTE = 8'hAA;
  localparam logic [DATA_W-1:0] MAGIC_BYTE = 8'hA5;

  // Storage map: magic word, length word, then payload bytes.
  localparam logic [ADDR_W-1:0] ADDR_MAGIC        = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_LENGTH       = 5'd1;
  localparam int                ADDR_PAYLOAD_BASE = 2;

  // Per-cycle control type used by every cell of the payload chain.
  typedef struct packed {
    logic shift;  // move every byte one cell toward the head
    logic load;   // capture the incoming received byte
  } cell_ctl_t;

endpackage

FILE: rtl/start_length_frame_commit.sv
// The last payload byte starts the write run; the first storage word is then registered.
// Throughput: one received byte per cycle while parsing; a frame of L bytes then emits
// L+2 words at one per cycle while wr_stall is low, paced by the payload chain shift.
// The receive side is stalled for the whole write run.
// Reset (synchronous, active high) returns the parser to idle and empties the output word.
`timescale 1ns / 1ps

module start_length_frame_commit #(
  parameter int MAX_PAYLOAD = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rx_valid,
  output logic                                rx_stall,
  input  logic [slfc_pkg::DATA_W-1:0]         rx_byte,
  output logic                                wr_valid,
  input  logic                                wr_stall,
  output logic [slfc_pkg::ADDR_W-1:0]         write_address,
  output logic [slfc_pkg::DATA_W-1:0]         write_data,
  output logic                                commit_last
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = $clog2(MAX_PAYLOAD + 2);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;
  localparam logic [1:0] PH_EMIT    = 2'd3;

  logic [1:0]                    phase;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 fill;
  logic [IW-1:0]                 emit_idx;
  logic                          rx_acc;
  logic                          out_free;
  logic                          step;
  logic                          emit_payload;
  logic                          emit_length;
  logic                          len_ok;
  logic [slfc_pkg::DATA_W-1:0]   chain_q [MAX_PAYLOAD];

  // The receive side is held off only while the write run is going out.
  assign rx_stall = (phase == PH_EMIT);
  assign rx_acc   = rx_valid && !rx_stall;

  // The output word may be refilled when empty or being taken this cycle.
  assign out_free     = !wr_valid || !wr_stall;
  assign step         = (phase == PH_EMIT) && out_free;
  assign emit_payload = (emit_idx < IW'(count));
  assign emit_length  = (emit_idx == IW'(count));

  assign len_ok = (rx_byte != '0) && (rx_byte <= slfc_pkg::DATA_W'(MAX_PAYLOAD));

  // Payload cell chain: cell i is filled by payload byte i, the run drains cell 0.
  for (genvar i = 0; i < MAX_PAYLOAD; i++) begin : g_cell
    slfc_pkg::cell_ctl_t           ctl;
    logic [slfc_pkg::DATA_W-1:0]   nbr;

    assign ctl.shift = step && emit_payload;
    assign ctl.load  = rx_acc && (phase == PH_COLLECT) && (fill == CW'(i));

    if (i == MAX_PAYLOAD - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = chain_q[i+1];
    end

    slfc_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .din (rx_byte),
      .nbr (nbr),
      .q   (chain_q[i])
    );
  end

  // Frame parser and write run sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      count    <= '0;
      fill     <= '0;
      emit_idx <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_acc && (rx_byte == slfc_pkg::START_BYTE)) begin
            phase <= PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (rx_acc) begin
            if (len_ok) begin
              count <= CW'(rx_byte);
              fill  <= '0;
              phase <= PH_COLLECT;
            end else begin
              phase <= PH_IDLE;
            end
          end
        end
        PH_COLLECT: begin
          if (rx_acc) begin
            fill <= fill + 1'b1;
            if (fill == count - 1'b1) begin
              emit_idx <= '0;
              phase    <= PH_EMIT;
            end
          end
        end
        PH_EMIT: begin
          if (step) begin
            emit_idx <= emit_idx + 1'b1;
            if (!emit_payload && !emit_length) begin
              phase <= PH_IDLE;
            end
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (out_free) begin
      wr_valid <= step;
    end
  end

  // Output word payload: payload bytes, then the length, then the committing magic word.
  always_ff @(posedge clk) begin
    if (step) begin
      if (emit_payload) begin
        write_address <= slfc_pkg::ADDR_W'(32'(emit_idx) + slfc_pkg::ADDR_PAYLOAD_BASE);
        write_data    <= chain_q[0];
        commit_last   <= 1'b0;
      end else if (emit_length) begin
        write_address <= slfc_pkg::ADDR_LENGTH;
        write_data    <= slfc_pkg::DATA_W'(count);
        commit_last   <= 1'b0;
      end else begin
        write_address <= slfc_pkg::ADDR_MAGIC;
        write_data    <= slfc_pkg::MAGIC_BYTE;
        commit_last   <= 1'b1;
      end
    end
  end

  // A commit word always carries the magic value at the magic address.
  a_commit_magic: assert property (@(posedge clk) disable iff (rst)
    wr_valid && commit_last |->
      (write_address == slfc_pkg::ADDR_MAGIC) && (write_data == slfc_pkg::MAGIC_BYTE))
    else $error("commit word without magic value");

  // While collecting, the length is legal and the fill position stays below it.
  a_collect_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLLECT) |->
      (count != '0) && (32'(count) <= MAX_PAYLOAD) && (fill < count))
    else $error("collection state out of range");

  // The write run never goes past the magic word.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT) |-> (32'(emit_idx) <= 32'(count) + 1))
    else $error("write run index past the end of the frame");

  // Leaving the write run coincides with loading the commit word.
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT) && step && !emit_payload && !emit_length |=>
      (phase == PH_IDLE) && wr_valid && commit_last)
    else $error("write run ended without a commit word");

endmodule

FILE: rtl/slfc_cell.sv
// One byte cell of the payload chain: loads a received byte or takes its neighbor's byte.
`timescale 1ns / 1ps

module slfc_cell (
  input  logic                          clk,
  input  slfc_pkg::cell_ctl_t           ctl,
  input  logic [slfc_pkg::DATA_W-1:0]   din,
  input  logic [slfc_pkg::DATA_W-1:0]   nbr,
  output logic [slfc_pkg::DATA_W-1:0]   q
);

  // Shifting during the write run wins; loading only happens while collecting.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= nbr;
    end else if (ctl.load) begin
      q <= din;
    end
  end

endmodule

FILE: tb/tb_start_length_frame_commit.sv
// Self-checking testbench for the start/length frame parser and its storage write run.
`timescale 1ns / 1ps

module tb_start_length_frame_commit;

  localparam int PAYLOAD_MAX  = 30;
  localparam int FRAME_ITEMS  = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {PH_IDLE, PH_LENGTH, PH_COLLECT} frame_phase_t;

  // How a directed row is checked: by the predictor, as producing no words,
  // or as the last byte of a one-byte frame.
  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_SINGLE} row_kind_t;

  typedef struct packed {
    logic [slfc_pkg::DATA_W-1:0] rx;
    row_kind_t                   kind;
  } stim_row_t;

  typedef struct packed {
    logic [slfc_pkg::ADDR_W-1:0] addr;
    logic [slfc_pkg::DATA_W-1:0] data;
    logic                        last;
  } storage_word_t;

  // Directed bytes: ignored bytes, rejected lengths, the start byte as data,
  // one-byte frames at the data extremes, and a short two-byte frame.
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    '{8'h00, ROW_QUIET}, '{8'hFF, ROW_QUIET},
    '{8'hAA, ROW_QUIET}, '{8'h00, ROW_QUIET},
    '{8'hAA, ROW_QUIET}, '{8'h1F, ROW_QUIET},
    '{8'hAA, ROW_QUIET}, '{8'hFF, ROW_QUIET},
    '{8'hAA, ROW_QUIET}, '{8'hAA, ROW_QUIET},
    '{8'hAA, ROW_QUIET}, '{8'h01, ROW_QUIET}, '{8'hAA, ROW_SINGLE},
    '{8'hAA, ROW_QUIET}, '{8'h01, ROW_QUIET}, '{8'h00, ROW_SINGLE},
    '{8'hAA, ROW_QUIET}, '{8'h01, ROW_QUIET}, '{8'hFF, ROW_SINGLE},
    '{8'hAA, ROW_QUIET}, '{8'h02, ROW_QUIET}, '{8'h55, ROW_QUIET},
    '{8'hAA, ROW_MODEL}
  };

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        rx_valid = 1'b0;
  logic [slfc_pkg::DATA_W-1:0] rx_byte  = '0;
  logic                        wr_stall = 1'b0;
  logic                        rx_stall;
  logic                        wr_valid;
  logic [slfc_pkg::ADDR_W-1:0] write_address;
  logic [slfc_pkg::DATA_W-1:0] write_data;
  logic                        commit_last;

  // Predictor state.
  frame_phase_t                parse_state = PH_IDLE;
  int unsigned                 frame_len   = 0;
  int unsigned                 frame_fill  = 0;
  logic [slfc_pkg::DATA_W-1:0] frame_bytes [PAYLOAD_MAX];

  storage_word_t words_due [$];
  int            send_idle_pct = 22;
  int            recv_idle_pct = 69;
  bit            hold_req      = 1'b0;
  bit            failed        = 1'b0;
  int unsigned   items_sent    = 0;
  int unsigned   cycle_count   = 0;

  start_length_frame_commit #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .wr_valid     (wr_valid),
    .wr_stall     (wr_stall),
    .write_address(write_address),
    .write_data   (write_data),
    .commit_last  (commit_last)
  );

  always #1 clk = ~clk;

  // Advance the frame parser by one byte and collect the storage words it releases.
  task automatic parse_frame_byte(input logic [slfc_pkg::DATA_W-1:0] b,
                                  ref storage_word_t words[$]);
    case (parse_state)
      PH_LENGTH: begin
        if (b >= 1 && b <= PAYLOAD_MAX) begin
          frame_len   = b;
          frame_fill  = 0;
          parse_state = PH_COLLECT;
        end else begin
          parse_state = PH_IDLE;
        end
      end
      PH_COLLECT: begin
        if (frame_fill < PAYLOAD_MAX) frame_bytes[frame_fill] = b;
        frame_fill++;
        if (frame_fill >= frame_len || frame_fill >= PAYLOAD_MAX) begin
          for (int j = 0; j < frame_len && j < PAYLOAD_MAX; j++)
            words.push_back(storage_word_t'{
              slfc_pkg::ADDR_W'(slfc_pkg::ADDR_PAYLOAD_BASE + j), frame_bytes[j], 1'b0});
          words.push_back(storage_word_t'{
            slfc_pkg::ADDR_LENGTH, slfc_pkg::DATA_W'(frame_len), 1'b0});
          words.push_back(storage_word_t'{slfc_pkg::ADDR_MAGIC, slfc_pkg::MAGIC_BYTE, 1'b1});
          parse_state = PH_IDLE;
        end
      end
      default: begin
        parse_state = (b == slfc_pkg::START_BYTE) ? PH_LENGTH : PH_IDLE;
      end
    endcase
  endtask

  // Offer one byte, wait for it to be taken, then record what it should produce.
  task automatic send_byte(input logic [slfc_pkg::DATA_W-1:0] b, input row_kind_t kind);
    storage_word_t words [$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall !== 1'b0) @(posedge clk);
    items_sent++;
    parse_frame_byte(b, words);
    case (kind)
      ROW_MODEL: begin
        foreach (words[i]) words_due.push_back(words[i]);
      end
      ROW_SINGLE: begin
        words_due.push_back(storage_word_t'{
          slfc_pkg::ADDR_W'(slfc_pkg::ADDR_PAYLOAD_BASE), b, 1'b0});
        words_due.push_back(storage_word_t'{slfc_pkg::ADDR_LENGTH, 8'h01, 1'b0});
        words_due.push_back(storage_word_t'{slfc_pkg::ADDR_MAGIC, slfc_pkg::MAGIC_BYTE, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  // A well-formed frame; most lengths are short, some take the full payload.
  task automatic send_frame();
    int unsigned len;
    case ($urandom_range(0, 9))
      0:       len = PAYLOAD_MAX;
      1, 2:    len = $urandom_range(1, PAYLOAD_MAX);
      default: len = $urandom_range(1, 6);
    endcase
    send_byte(slfc_pkg::START_BYTE, ROW_MODEL);
    send_byte(slfc_pkg::DATA_W'(len), ROW_MODEL);
    repeat (len) send_byte(slfc_pkg::DATA_W'($urandom_range(0, 255)), ROW_MODEL);
  endtask

  // Noise: a header with a rejected length, or a stray byte between frames.
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_byte(slfc_pkg::START_BYTE, ROW_MODEL);
      if ($urandom_range(0, 1) == 0) send_byte('0, ROW_MODEL);
      else send_byte(slfc_pkg::DATA_W'($urandom_range(PAYLOAD_MAX + 1, 255)), ROW_MODEL);
    end else begin
      send_byte(slfc_pkg::DATA_W'($urandom_range(0, 255)), ROW_MODEL);
    end
  endtask

  // Stimulus: directed table, then random frames and noise in three idling stages.
  initial begin : stimulus
    int stage;
    stage = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_ROWS[i]) send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].kind);
    while (items_sent < FRAME_ITEMS) begin
      if (stage == 0 && items_sent >= FRAME_ITEMS / 3) begin
        // Let every pending word drain before swapping the idle rates.
        rx_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge clk);
        send_idle_pct = 69;
        recv_idle_pct = 22;
        stage = 1;
      end else if (stage == 1 && items_sent >= 2 * FRAME_ITEMS / 3) begin
        // No idling from here on; the receiver holds off once so input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        stage = 2;
      end
      if ($urandom_range(0, 9) < 8) send_frame();
      else send_noise();
    end
    rx_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

  // Receiver stall: random per cycle, or one long hold when requested.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        wr_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wr_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare each accepted storage word with the oldest pending one.
  always @(posedge clk) begin : check_words
    storage_word_t want;
    if (!rst && wr_valid === 1'b1 && wr_stall === 1'b0) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: address %0d data 0x%02h last %0b",
               write_address, write_data, commit_last);
        failed = 1'b1;
      end else begin
        want = words_due.pop_front();
        if (write_address !== want.addr) begin
          $error("write_address: expected %0d, got %0d", want.addr, write_address);
          failed = 1'b1;
        end
        if (write_data !== want.data) begin
          $error("write_data: expected 0x%02h, got 0x%02h", want.data, write_data);
          failed = 1'b1;
        end
        if (commit_last !== want.last) begin
          $error("commit_last: expected %0b, got %0b", want.last, commit_last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
